// ----- rtl/acs_pkg.sv -----
`default_nettype none
package acs_pkg;

  localparam int ADDR_BITS_DEF = 20;
  localparam int APB_ADDR_W    = 2;

  localparam logic [23:0] START_DEFAULT = 24'h070000;
  localparam logic [23:0] PORT_KEY      = 24'hfffffd;
  localparam logic [23:0] PORT_STROBE   = 24'hfffffe;
  localparam logic [23:0] PORT_DATA     = 24'hffffff;

  localparam logic MODE_LOAD = 1'b0;

  // opcodes
  localparam logic [7:0] OP_HLT   = 8'd0;
  localparam logic [7:0] OP_LXI   = 8'd1;
  localparam logic [7:0] OP_LDX   = 8'd2;
  localparam logic [7:0] OP_ADX   = 8'd3;
  localparam logic [7:0] OP_SBX   = 8'd4;
  localparam logic [7:0] OP_STX   = 8'd5;
  localparam logic [7:0] OP_LAI   = 8'd6;
  localparam logic [7:0] OP_LD    = 8'd7;
  localparam logic [7:0] OP_ST    = 8'd8;
  localparam logic [7:0] OP_ADC   = 8'd9;
  localparam logic [7:0] OP_SBB   = 8'd10;
  localparam logic [7:0] OP_AND   = 8'd11;
  localparam logic [7:0] OP_OR    = 8'd12;
  localparam logic [7:0] OP_RORX  = 8'd13;
  localparam logic [7:0] OP_ROLX  = 8'd14;
  localparam logic [7:0] OP_JMP   = 8'd15;
  localparam logic [7:0] OP_JZ    = 8'd16;
  localparam logic [7:0] OP_JNZ   = 8'd17;
  localparam logic [7:0] OP_JC    = 8'd18;
  localparam logic [7:0] OP_JNC   = 8'd19;
  localparam logic [7:0] OP_JMPX  = 8'd20;
  localparam logic [7:0] OP_JMPY  = 8'd21;
  localparam logic [7:0] OP_LYI   = 8'd22;
  localparam logic [7:0] OP_LDY   = 8'd23;
  localparam logic [7:0] OP_ADY   = 8'd24;
  localparam logic [7:0] OP_SBY   = 8'd25;
  localparam logic [7:0] OP_STY   = 8'd26;
  localparam logic [7:0] OP_LD_Y  = 8'd27;
  localparam logic [7:0] OP_ST_Y  = 8'd28;
  localparam logic [7:0] OP_ADC_Y = 8'd29;
  localparam logic [7:0] OP_SBB_Y = 8'd30;
  localparam logic [7:0] OP_AND_Y = 8'd31;
  localparam logic [7:0] OP_OR_Y  = 8'd32;
  localparam logic [7:0] OP_CALL  = 8'd33;
  localparam logic [7:0] OP_RET   = 8'd34;
  localparam logic [7:0] OP_PUSHA = 8'd35;
  localparam logic [7:0] OP_PUSHX = 8'd36;
  localparam logic [7:0] OP_POPA  = 8'd37;
  localparam logic [7:0] OP_POPX  = 8'd38;
  localparam logic [7:0] OP_TXS   = 8'd39;
  localparam logic [7:0] OP_TSX   = 8'd40;
  localparam logic [7:0] OP_INCX  = 8'd41;
  localparam logic [7:0] OP_DECX  = 8'd42;
  localparam logic [7:0] OP_INCY  = 8'd43;
  localparam logic [7:0] OP_DECY  = 8'd44;
  localparam logic [7:0] OP_RORY  = 8'd45;
  localparam logic [7:0] OP_ROLY  = 8'd46;

  typedef enum logic [3:0] {
    ALU_ADC, ALU_SBB, ALU_AND, ALU_OR, ALU_ROR, ALU_ROL,
    ALU_ADD24, ALU_SUB24, ALU_INC24, ALU_DEC24
  } alu_op_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_DECODE, S_OPND, S_OPND_W, S_WRD, S_WRD_W,
    S_WWR, S_MRD, S_MRD_W, S_PUSH, S_POP, S_POP_W, S_KEY, S_STB, S_STB_W,
    S_DAT, S_DAT_W, S_DONE
  } state_t;

  typedef struct packed {
    logic        mode;
    logic [23:0] load_address;
    logic [7:0]  load_byte;
    logic [7:0]  key_code;
  } in_t;

  typedef struct packed {
    logic        char_valid;
    logic [7:0]  char_out;
    logic        halted;
    logic [23:0] pc_out;
    logic [7:0]  acc_out;
    logic [23:0] x_out;
    logic [23:0] y_out;
    logic [23:0] sp_out;
    logic        carry_out;
    logic        zero_out;
  } out_t;

  typedef struct packed {
    alu_op_t     op;
    logic [23:0] a;
    logic [23:0] b;
    logic        cin;
  } alu_req_t;

  typedef struct packed {
    logic [23:0] res;
    logic        carry;
    logic        zero;
  } alu_rsp_t;

  typedef struct packed {
    logic        we;
    logic [23:0] addr;
    logic [7:0]  wdata;
  } mem_req_t;

  typedef struct packed {
    logic        we;
    logic [23:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic ready;
    logic done;
  } core_stat_t;

endpackage
`default_nettype wire

// ----- rtl/acs_alu.sv -----
`default_nettype none
module acs_alu (
  input  acs_pkg::alu_req_t req,
  output acs_pkg::alu_rsp_t rsp
);

  logic [23:0] bx;
  logic        ci;
  logic [24:0] sum;
  logic [7:0]  r8;

  always_comb begin
    case (req.op)
      acs_pkg::ALU_ADC:   begin bx = {16'b0, req.b[7:0]};  ci = req.cin; end
      acs_pkg::ALU_SBB:   begin bx = {16'b0, ~req.b[7:0]}; ci = req.cin; end
      acs_pkg::ALU_ADD24: begin bx = req.b;                ci = 1'b0;    end
      acs_pkg::ALU_SUB24: begin bx = ~req.b;               ci = 1'b1;    end
      acs_pkg::ALU_INC24: begin bx = 24'd0;                ci = 1'b1;    end
      acs_pkg::ALU_DEC24: begin bx = 24'hffffff;           ci = 1'b0;    end
      default:            begin bx = 24'd0;                ci = 1'b0;    end
    endcase
    sum = {1'b0, req.a} + {1'b0, bx} + {24'b0, ci};
  end

  always_comb begin
    r8        = 8'd0;
    rsp.res   = sum[23:0];
    rsp.carry = sum[24];
    rsp.zero  = (sum[23:0] == 24'd0);
    case (req.op)
      acs_pkg::ALU_ADC, acs_pkg::ALU_SBB: begin
        r8        = sum[7:0];
        rsp.carry = sum[8];
      end
      acs_pkg::ALU_AND: begin
        r8        = req.a[7:0] & req.b[7:0];
        rsp.carry = 1'b0;
      end
      acs_pkg::ALU_OR: begin
        r8        = req.a[7:0] | req.b[7:0];
        rsp.carry = 1'b1;
      end
      acs_pkg::ALU_ROR: begin
        r8        = {req.cin, req.b[7:1]};
        rsp.carry = req.b[0];
      end
      acs_pkg::ALU_ROL: begin
        r8        = {req.b[6:0], req.cin};
        rsp.carry = req.b[7];
      end
      acs_pkg::ALU_ADD24: rsp.zero = (sum == 25'd0);  // full sum, carry included
      default: ;
    endcase
    case (req.op)
      acs_pkg::ALU_ADC, acs_pkg::ALU_SBB, acs_pkg::ALU_AND, acs_pkg::ALU_OR,
      acs_pkg::ALU_ROR, acs_pkg::ALU_ROL: begin
        rsp.res  = {16'b0, r8};
        rsp.zero = (r8 == 8'd0);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/acs_mem.sv -----
`default_nettype none
module acs_mem #(
  parameter int ADDR_BITS = acs_pkg::ADDR_BITS_DEF
) (
  input  wire               clk,
  input  acs_pkg::mem_req_t req,
  output logic [7:0]        rdata
);

  logic [7:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr[ADDR_BITS-1:0]] <= req.wdata;
    end else begin
      rdata <= mem[req.addr[ADDR_BITS-1:0]];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/acs_core.sv -----
`default_nettype none
module acs_core #(
  parameter int ADDR_BITS = acs_pkg::ADDR_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  acs_pkg::in_t        item,
  input  acs_pkg::cfg_wr_t    cfg,
  input  wire                 slot_free,
  input  wire [7:0]           rdata,
  output acs_pkg::core_stat_t stat,
  output acs_pkg::out_t       res,
  output acs_pkg::mem_req_t   mreq
);

  acs_pkg::state_t state, state_next;
  logic [23:0] pc, pc_next, sp, sp_next, x, x_next, y, y_next;
  logic [7:0]  acc, acc_next;
  logic        cf, cf_next, zf, zf_next, hf, hf_next;
  logic [7:0]  op, op_next, key, key_next, co, co_next;
  logic        cv, cv_next;
  logic [23:0] t, t_next, ea, ea_next, d, d_next;
  logic [1:0]  cnt, cnt_next;
  logic [ADDR_BITS-1:0] clr_addr, clr_addr_next;
  logic [23:0] t_new;
  logic        last;

  acs_pkg::alu_req_t areq;
  acs_pkg::alu_rsp_t arsp;

  acs_alu u_alu (.req(areq), .rsp(arsp));

  assign t_new = {rdata, t[23:8]};  // little-endian byte assembly
  assign last  = (cnt == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= acs_pkg::S_CLEAR;
      clr_addr <= '0;
      pc       <= acs_pkg::START_DEFAULT;
      sp       <= 24'd0;
      x        <= 24'd0;
      y        <= 24'd0;
      acc      <= 8'd0;
      cf       <= 1'b0;
      zf       <= 1'b0;
      hf       <= 1'b0;
      cv       <= 1'b0;
      co       <= 8'd0;
      cnt      <= 2'd0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      pc       <= pc_next;
      sp       <= sp_next;
      x        <= x_next;
      y        <= y_next;
      acc      <= acc_next;
      cf       <= cf_next;
      zf       <= zf_next;
      hf       <= hf_next;
      cv       <= cv_next;
      co       <= co_next;
      cnt      <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    op  <= op_next;
    key <= key_next;
    t   <= t_next;
    ea  <= ea_next;
    d   <= d_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      acs_pkg::S_CLEAR: if (clr_addr == '1) state_next = acs_pkg::S_IDLE;
      acs_pkg::S_IDLE: begin
        if (start) begin
          if (item.mode == acs_pkg::MODE_LOAD || hf) state_next = acs_pkg::S_DONE;
          else                                       state_next = acs_pkg::S_FETCH;
        end
      end
      acs_pkg::S_FETCH: state_next = acs_pkg::S_DECODE;
      acs_pkg::S_DECODE: begin
        case (rdata) inside
          acs_pkg::OP_LXI, acs_pkg::OP_LDX, acs_pkg::OP_ADX, acs_pkg::OP_SBX,
          acs_pkg::OP_STX, acs_pkg::OP_LAI, acs_pkg::OP_JMP, acs_pkg::OP_JZ,
          acs_pkg::OP_JNZ, acs_pkg::OP_JC, acs_pkg::OP_JNC, acs_pkg::OP_LYI,
          acs_pkg::OP_LDY, acs_pkg::OP_ADY, acs_pkg::OP_SBY, acs_pkg::OP_STY,
          acs_pkg::OP_CALL:
            state_next = acs_pkg::S_OPND;
          acs_pkg::OP_LD, acs_pkg::OP_ADC, acs_pkg::OP_SBB, acs_pkg::OP_AND,
          acs_pkg::OP_OR, acs_pkg::OP_RORX, acs_pkg::OP_ROLX, acs_pkg::OP_LD_Y,
          acs_pkg::OP_ADC_Y, acs_pkg::OP_SBB_Y, acs_pkg::OP_AND_Y, acs_pkg::OP_OR_Y,
          acs_pkg::OP_RORY, acs_pkg::OP_ROLY:
            state_next = acs_pkg::S_MRD;
          acs_pkg::OP_RET, acs_pkg::OP_POPA, acs_pkg::OP_POPX:
            state_next = acs_pkg::S_POP;
          acs_pkg::OP_PUSHA, acs_pkg::OP_PUSHX:
            state_next = acs_pkg::S_PUSH;
          default: state_next = acs_pkg::S_KEY;
        endcase
      end
      acs_pkg::S_OPND: state_next = acs_pkg::S_OPND_W;
      acs_pkg::S_OPND_W: begin
        if (!last) begin
          state_next = acs_pkg::S_OPND;
        end else begin
          case (op) inside
            acs_pkg::OP_LDX, acs_pkg::OP_ADX, acs_pkg::OP_SBX,
            acs_pkg::OP_LDY, acs_pkg::OP_ADY, acs_pkg::OP_SBY:
              state_next = acs_pkg::S_WRD;
            acs_pkg::OP_STX, acs_pkg::OP_STY: state_next = acs_pkg::S_WWR;
            acs_pkg::OP_CALL:                 state_next = acs_pkg::S_PUSH;
            default:                          state_next = acs_pkg::S_KEY;
          endcase
        end
      end
      acs_pkg::S_WRD:   state_next = acs_pkg::S_WRD_W;
      acs_pkg::S_WRD_W: state_next = last ? acs_pkg::S_KEY : acs_pkg::S_WRD;
      acs_pkg::S_WWR:   state_next = last ? acs_pkg::S_KEY : acs_pkg::S_WWR;
      acs_pkg::S_MRD:   state_next = acs_pkg::S_MRD_W;
      acs_pkg::S_MRD_W: state_next = acs_pkg::S_KEY;
      acs_pkg::S_PUSH:  state_next = last ? acs_pkg::S_KEY : acs_pkg::S_PUSH;
      acs_pkg::S_POP:   state_next = acs_pkg::S_POP_W;
      acs_pkg::S_POP_W: state_next = last ? acs_pkg::S_KEY : acs_pkg::S_POP;
      acs_pkg::S_KEY:   state_next = acs_pkg::S_STB;
      acs_pkg::S_STB:   state_next = acs_pkg::S_STB_W;
      acs_pkg::S_STB_W: state_next = (rdata != 8'd0) ? acs_pkg::S_DAT : acs_pkg::S_DONE;
      acs_pkg::S_DAT:   state_next = acs_pkg::S_DAT_W;
      acs_pkg::S_DAT_W: state_next = acs_pkg::S_DONE;
      acs_pkg::S_DONE:  if (slot_free) state_next = acs_pkg::S_IDLE;
      default:          state_next = acs_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    pc_next       = pc;
    sp_next       = sp;
    x_next        = x;
    y_next        = y;
    acc_next      = acc;
    cf_next       = cf;
    zf_next       = zf;
    hf_next       = hf;
    op_next       = op;
    key_next      = key;
    cv_next       = cv;
    co_next       = co;
    t_next        = t;
    ea_next       = ea;
    d_next        = d;
    cnt_next      = cnt;
    clr_addr_next = clr_addr;
    mreq.we       = 1'b0;
    mreq.addr     = pc;
    mreq.wdata    = 8'd0;
    areq.op       = acs_pkg::ALU_ADD24;
    areq.a        = 24'd0;
    areq.b        = 24'd0;
    areq.cin      = 1'b0;
    stat.done     = 1'b0;

    unique case (state)
      acs_pkg::S_CLEAR: begin
        mreq.we       = 1'b1;
        mreq.addr     = 24'(clr_addr);
        clr_addr_next = clr_addr + 1'b1;
      end
      acs_pkg::S_IDLE: begin
        if (start) begin
          cv_next  = 1'b0;
          co_next  = 8'd0;
          key_next = item.key_code;
          if (item.mode == acs_pkg::MODE_LOAD) begin
            mreq.we    = 1'b1;
            mreq.addr  = item.load_address;
            mreq.wdata = item.load_byte;
          end
        end
      end
      acs_pkg::S_FETCH: begin
        mreq.addr = pc;
        pc_next   = pc + 24'd1;
      end
      acs_pkg::S_DECODE: begin
        op_next = rdata;
        case (rdata) inside
          acs_pkg::OP_HLT: hf_next = 1'b1;
          acs_pkg::OP_LXI, acs_pkg::OP_LDX, acs_pkg::OP_ADX, acs_pkg::OP_SBX,
          acs_pkg::OP_STX, acs_pkg::OP_JMP, acs_pkg::OP_JZ, acs_pkg::OP_JNZ,
          acs_pkg::OP_JC, acs_pkg::OP_JNC, acs_pkg::OP_LYI, acs_pkg::OP_LDY,
          acs_pkg::OP_ADY, acs_pkg::OP_SBY, acs_pkg::OP_STY, acs_pkg::OP_CALL:
            cnt_next = 2'd3;
          acs_pkg::OP_LAI: cnt_next = 2'd1;
          acs_pkg::OP_LD, acs_pkg::OP_ADC, acs_pkg::OP_SBB, acs_pkg::OP_AND,
          acs_pkg::OP_OR, acs_pkg::OP_RORX, acs_pkg::OP_ROLX:
            ea_next = x;
          acs_pkg::OP_LD_Y, acs_pkg::OP_ADC_Y, acs_pkg::OP_SBB_Y, acs_pkg::OP_AND_Y,
          acs_pkg::OP_OR_Y, acs_pkg::OP_RORY, acs_pkg::OP_ROLY:
            ea_next = y;
          acs_pkg::OP_ST: begin
            mreq.we    = 1'b1;
            mreq.addr  = x;
            mreq.wdata = acc;
          end
          acs_pkg::OP_ST_Y: begin
            mreq.we    = 1'b1;
            mreq.addr  = y;
            mreq.wdata = acc;
          end
          acs_pkg::OP_JMPX: pc_next = x;
          acs_pkg::OP_JMPY: pc_next = y;
          acs_pkg::OP_RET, acs_pkg::OP_POPX: cnt_next = 2'd3;
          acs_pkg::OP_POPA: cnt_next = 2'd1;
          acs_pkg::OP_PUSHA: begin
            d_next   = {acc, 16'd0};
            cnt_next = 2'd1;
          end
          acs_pkg::OP_PUSHX: begin
            d_next   = x;
            cnt_next = 2'd3;
          end
          acs_pkg::OP_TXS: sp_next = x;
          acs_pkg::OP_TSX: x_next = sp;
          acs_pkg::OP_INCX, acs_pkg::OP_DECX: begin
            areq.op = (rdata == acs_pkg::OP_INCX) ? acs_pkg::ALU_INC24 : acs_pkg::ALU_DEC24;
            areq.a  = x;
            x_next  = arsp.res;
            zf_next = arsp.zero;
          end
          acs_pkg::OP_INCY, acs_pkg::OP_DECY: begin
            areq.op = (rdata == acs_pkg::OP_INCY) ? acs_pkg::ALU_INC24 : acs_pkg::ALU_DEC24;
            areq.a  = y;
            y_next  = arsp.res;
            zf_next = arsp.zero;
          end
          default: ;
        endcase
      end
      acs_pkg::S_OPND: begin
        mreq.addr = pc;
        pc_next   = pc + 24'd1;
      end
      acs_pkg::S_OPND_W: begin
        t_next   = t_new;
        cnt_next = cnt - 2'd1;
        if (last) begin
          case (op) inside
            acs_pkg::OP_LXI: x_next = t_new;
            acs_pkg::OP_LYI: y_next = t_new;
            acs_pkg::OP_LAI: acc_next = rdata;
            acs_pkg::OP_JMP: pc_next = t_new;
            acs_pkg::OP_JZ:  if (zf)  pc_next = t_new;
            acs_pkg::OP_JNZ: if (!zf) pc_next = t_new;
            acs_pkg::OP_JC:  if (cf)  pc_next = t_new;
            acs_pkg::OP_JNC: if (!cf) pc_next = t_new;
            acs_pkg::OP_LDX, acs_pkg::OP_ADX, acs_pkg::OP_SBX,
            acs_pkg::OP_LDY, acs_pkg::OP_ADY, acs_pkg::OP_SBY: begin
              ea_next  = t_new;
              cnt_next = 2'd3;
            end
            acs_pkg::OP_STX, acs_pkg::OP_STY: begin
              ea_next  = t_new;
              d_next   = (op == acs_pkg::OP_STX) ? x : y;
              cnt_next = 2'd3;
            end
            acs_pkg::OP_CALL: begin
              d_next   = pc;  // return address, already past the operand
              cnt_next = 2'd3;
            end
            default: ;
          endcase
        end
      end
      acs_pkg::S_WRD: begin
        mreq.addr = ea;
        ea_next   = ea + 24'd1;
      end
      acs_pkg::S_WRD_W: begin
        t_next   = t_new;
        cnt_next = cnt - 2'd1;
        if (last) begin
          case (op) inside
            acs_pkg::OP_LDX: x_next = t_new;
            acs_pkg::OP_LDY: y_next = t_new;
            acs_pkg::OP_ADX, acs_pkg::OP_SBX: begin
              areq.op = (op == acs_pkg::OP_ADX) ? acs_pkg::ALU_ADD24 : acs_pkg::ALU_SUB24;
              areq.a  = x;
              areq.b  = t_new;
              x_next  = arsp.res;
              cf_next = arsp.carry;
              zf_next = arsp.zero;
            end
            acs_pkg::OP_ADY, acs_pkg::OP_SBY: begin
              areq.op = (op == acs_pkg::OP_ADY) ? acs_pkg::ALU_ADD24 : acs_pkg::ALU_SUB24;
              areq.a  = y;
              areq.b  = t_new;
              y_next  = arsp.res;
              cf_next = arsp.carry;
              zf_next = arsp.zero;
            end
            default: ;
          endcase
        end
      end
      acs_pkg::S_WWR: begin
        mreq.we    = 1'b1;
        mreq.addr  = ea;
        mreq.wdata = d[7:0];
        d_next     = {8'd0, d[23:8]};
        ea_next    = ea + 24'd1;
        cnt_next   = cnt - 2'd1;
      end
      acs_pkg::S_MRD: mreq.addr = ea;
      acs_pkg::S_MRD_W: begin
        areq.a   = {16'd0, acc};
        areq.b   = {16'd0, rdata};
        areq.cin = cf;
        case (op) inside
          acs_pkg::OP_ADC, acs_pkg::OP_ADC_Y: areq.op = acs_pkg::ALU_ADC;
          acs_pkg::OP_SBB, acs_pkg::OP_SBB_Y: areq.op = acs_pkg::ALU_SBB;
          acs_pkg::OP_AND, acs_pkg::OP_AND_Y: areq.op = acs_pkg::ALU_AND;
          acs_pkg::OP_OR,  acs_pkg::OP_OR_Y:  areq.op = acs_pkg::ALU_OR;
          acs_pkg::OP_RORX, acs_pkg::OP_RORY: areq.op = acs_pkg::ALU_ROR;
          acs_pkg::OP_ROLX, acs_pkg::OP_ROLY: areq.op = acs_pkg::ALU_ROL;
          default: ;
        endcase
        case (op) inside
          acs_pkg::OP_LD, acs_pkg::OP_LD_Y: acc_next = rdata;
          acs_pkg::OP_RORX, acs_pkg::OP_RORY, acs_pkg::OP_ROLX, acs_pkg::OP_ROLY: begin
            mreq.we    = 1'b1;
            mreq.addr  = ea;
            mreq.wdata = arsp.res[7:0];
            cf_next    = arsp.carry;
            zf_next    = arsp.zero;
          end
          default: begin
            acc_next = arsp.res[7:0];
            cf_next  = arsp.carry;
            zf_next  = arsp.zero;
          end
        endcase
      end
      acs_pkg::S_PUSH: begin
        mreq.we    = 1'b1;
        mreq.addr  = sp - 24'd1;
        mreq.wdata = d[23:16];
        sp_next    = sp - 24'd1;
        d_next     = {d[15:0], 8'd0};
        cnt_next   = cnt - 2'd1;
        if (last && op == acs_pkg::OP_CALL) pc_next = t;
      end
      acs_pkg::S_POP: begin
        mreq.addr = sp;
        sp_next   = sp + 24'd1;
      end
      acs_pkg::S_POP_W: begin
        t_next   = t_new;
        cnt_next = cnt - 2'd1;
        if (last) begin
          case (op) inside
            acs_pkg::OP_RET:  pc_next = t_new;
            acs_pkg::OP_POPX: x_next = t_new;
            acs_pkg::OP_POPA: acc_next = rdata;
            default: ;
          endcase
        end
      end
      acs_pkg::S_KEY: begin
        if (key != 8'd0) begin
          mreq.we    = 1'b1;
          mreq.addr  = acs_pkg::PORT_KEY;
          mreq.wdata = key;
        end
      end
      acs_pkg::S_STB: mreq.addr = acs_pkg::PORT_STROBE;
      acs_pkg::S_STB_W: begin
        if (rdata != 8'd0) begin
          mreq.we   = 1'b1;
          mreq.addr = acs_pkg::PORT_STROBE;
          cv_next   = 1'b1;
        end
      end
      acs_pkg::S_DAT:   mreq.addr = acs_pkg::PORT_DATA;
      acs_pkg::S_DAT_W: co_next = rdata;
      acs_pkg::S_DONE:  stat.done = slot_free;
      default: ;
    endcase

    if (cfg.we) pc_next = cfg.value;
  end

  assign stat.ready = (state == acs_pkg::S_IDLE);

  assign res.char_valid = cv;
  assign res.char_out   = co;
  assign res.halted     = hf;
  assign res.pc_out     = pc;
  assign res.acc_out    = acc;
  assign res.x_out      = x;
  assign res.y_out      = y;
  assign res.sp_out     = sp;
  assign res.carry_out  = cf;
  assign res.zero_out   = zf;

endmodule
`default_nettype wire

// ----- rtl/accumulator_cpu_step.sv -----
`default_nettype none
// Channel   | Signals                          | Dir | Notes
// in        | in_valid/in_ready/in_data        | in  | one transaction = load byte or step
// out       | out_valid/out_ready/out_data     | out | one transaction per input item
// apb       | psel/penable/pwrite/paddr/...    | in  | start_address at byte address 0
//
// Steps: a load item or a halted step goes straight to the result; an executed
// instruction is paced by the single-port byte memory: each byte read needs an
// address state and then a data state, each write needs only one state, and port
// handling follows at the end of every instruction.
// Reset: after rst the memory is swept to zero, one byte a cycle over all
// 2**ADDR_BITS bytes, with in_ready low; APB writes are taken meanwhile.
// Stalls: the result sits in an output register; the core runs the next item
// and waits at its end only while that register is still full.
module accumulator_cpu_step #(
  parameter int ADDR_BITS = acs_pkg::ADDR_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  acs_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  wire                               out_ready,
  output acs_pkg::out_t                     out_data,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire [acs_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire [31:0]                        pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [23:0]         start_addr;
  logic                start;
  logic                slot_free;
  acs_pkg::cfg_wr_t    cfg;
  acs_pkg::core_stat_t stat;
  acs_pkg::out_t       res;
  acs_pkg::mem_req_t   mreq;
  logic [7:0]          rdata;

  // APB: single register, no wait states; a write takes pwdata[23:0] whole
  assign pready    = 1'b1;
  assign cfg.we    = psel && penable && pwrite && (paddr[acs_pkg::APB_ADDR_W-1:2] == '0);
  assign cfg.value = pwdata[23:0];
  assign prdata    = {8'd0, start_addr};

  always_ff @(posedge clk) begin
    if (rst) begin
      start_addr <= acs_pkg::START_DEFAULT;
    end else if (cfg.we) begin
      start_addr <= cfg.value;
    end
  end

  // input side: the core takes an item only from its idle state
  assign in_ready  = stat.ready;
  assign start     = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  acs_core #(.ADDR_BITS(ADDR_BITS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (in_data),
    .cfg       (cfg),
    .slot_free (slot_free),
    .rdata     (rdata),
    .stat      (stat),
    .res       (res),
    .mreq      (mreq)
  );

  acs_mem #(.ADDR_BITS(ADDR_BITS)) u_mem (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  // output register: loaded when the core finishes and the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) out_data <= res;
  end

  // the core never finishes into a full output register
  a_done_slot: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> (!out_valid || out_ready))
    else $error("result finished while output register full");

  // an accepted item makes the core busy on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("core still ready after accepting an item");

  // halt is sticky until reset
  a_halt: assert property (@(posedge clk) disable iff (rst)
    res.halted |=> res.halted)
    else $error("halt flag cleared");

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import acs_pkg::*;

  // ---------------------------------------------------------------------------
  // Constants
  // ---------------------------------------------------------------------------
  localparam int   MEM_AW     = ADDR_BITS_DEF;
  localparam int   MEM_SIZE   = 1 << MEM_AW;
  // The block sweeps its memory after reset with nothing accepted, so the
  // no-progress limit has to cover that clearing pass several times over.
  localparam int   IDLE_LIMIT = 3 * MEM_SIZE + 20000;
  localparam int   LONG_HOLD  = 400;
  localparam int   SETTLE     = 40;
  localparam logic MODE_EXEC  = ~MODE_LOAD;
  localparam logic [APB_ADDR_W-1:0] REG_START_ADDR = '0;

  // ---------------------------------------------------------------------------
  // DUT signals
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  accumulator_cpu_step i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // CPU predictor: architectural state mirrored at the block's widths
  // ---------------------------------------------------------------------------
  logic [23:0] cpu_start;
  logic [23:0] cpu_pc;
  logic [23:0] cpu_sp;
  logic [23:0] cpu_x;
  logic [23:0] cpu_y;
  logic [7:0]  cpu_acc;
  logic        cpu_cf;
  logic        cpu_zf;
  logic        cpu_halt;
  logic [7:0]  cpu_mem [MEM_SIZE];

  // expected step results, oldest first
  out_t step_results_q[$];
  int   error_count;

  function automatic logic [7:0] mem_rd(logic [23:0] a);
    return cpu_mem[a[MEM_AW-1:0]];
  endfunction

  function automatic void mem_wr(logic [23:0] a, logic [7:0] v);
    cpu_mem[a[MEM_AW-1:0]] = v;
  endfunction

  function automatic logic [7:0] fetch8();
    logic [7:0] v;
    v = mem_rd(cpu_pc);
    cpu_pc = cpu_pc + 24'd1;
    return v;
  endfunction

  // little-endian operand, bytes taken in address order
  function automatic logic [23:0] fetch24();
    logic [7:0] lo, mid, hi;
    lo  = fetch8();
    mid = fetch8();
    hi  = fetch8();
    return {hi, mid, lo};
  endfunction

  function automatic logic [23:0] rd24(logic [23:0] a);
    return {mem_rd(a + 24'd2), mem_rd(a + 24'd1), mem_rd(a)};
  endfunction

  function automatic void wr24(logic [23:0] a, logic [23:0] v);
    mem_wr(a, v[7:0]);
    mem_wr(a + 24'd1, v[15:8]);
    mem_wr(a + 24'd2, v[23:16]);
  endfunction

  function automatic void push8(logic [7:0] v);
    cpu_sp = cpu_sp - 24'd1;
    mem_wr(cpu_sp, v);
  endfunction

  function automatic logic [7:0] pop8();
    logic [7:0] v;
    v = mem_rd(cpu_sp);
    cpu_sp = cpu_sp + 24'd1;
    return v;
  endfunction

  function automatic void push24(logic [23:0] v);
    push8(v[23:16]);
    push8(v[15:8]);
    push8(v[7:0]);
  endfunction

  function automatic logic [23:0] pop24();
    logic [7:0] lo, mid, hi;
    lo  = pop8();
    mid = pop8();
    hi  = pop8();
    return {hi, mid, lo};
  endfunction

  // zero comes from the full 25-bit sum, not the masked register
  function automatic logic [23:0] add24(logic [23:0] r, logic [23:0] m);
    logic [24:0] s;
    s = {1'b0, r} + {1'b0, m};
    cpu_zf = (s == 25'd0);
    cpu_cf = s[24];
    return s[23:0];
  endfunction

  // carry set when no borrow
  function automatic logic [23:0] sub24(logic [23:0] r, logic [23:0] m);
    cpu_zf = (r == m);
    cpu_cf = (r >= m);
    return r - m;
  endfunction

  function automatic void set_acc(logic [7:0] v);
    cpu_acc = v;
    cpu_zf  = (v == 8'd0);
  endfunction

  function automatic void alu_mem(logic [23:0] a, alu_op_t kind);
    logic [9:0] m, s, subtrahend;
    m = {2'b0, mem_rd(a)};
    case (kind)
      ALU_ADC: begin
        s = {2'b0, cpu_acc} + m + {9'd0, cpu_cf};
        cpu_cf = (s > 10'd255);
        set_acc(s[7:0]);
      end
      ALU_SBB: begin
        subtrahend = m + 10'd1 - {9'd0, cpu_cf};
        cpu_cf = ({2'b0, cpu_acc} >= subtrahend);
        s = {2'b0, cpu_acc} - subtrahend;
        set_acc(s[7:0]);
      end
      ALU_AND: begin
        set_acc(cpu_acc & m[7:0]);
        cpu_cf = 1'b0;
      end
      default: begin
        set_acc(cpu_acc | m[7:0]);
        cpu_cf = 1'b1;
      end
    endcase
  endfunction

  function automatic void rotate_mem(logic [23:0] a, logic left);
    logic [7:0] old, nv;
    old = mem_rd(a);
    nv  = left ? {old[6:0], cpu_cf} : {cpu_cf, old[7:1]};
    mem_wr(a, nv);
    cpu_zf = (nv == 8'd0);
    cpu_cf = left ? old[7] : old[0];
  endfunction

  function automatic void run_instruction();
    logic [7:0]  op;
    logic [23:0] t;
    op = fetch8();
    case (op)
      OP_HLT:   cpu_halt = 1'b1;
      OP_LXI:   cpu_x = fetch24();
      OP_LDX:   cpu_x = rd24(fetch24());
      OP_ADX:   begin t = fetch24(); cpu_x = add24(cpu_x, rd24(t)); end
      OP_SBX:   begin t = fetch24(); cpu_x = sub24(cpu_x, rd24(t)); end
      OP_STX:   wr24(fetch24(), cpu_x);
      OP_LAI:   cpu_acc = fetch8();
      OP_LD:    cpu_acc = mem_rd(cpu_x);
      OP_ST:    mem_wr(cpu_x, cpu_acc);
      OP_ADC:   alu_mem(cpu_x, ALU_ADC);
      OP_SBB:   alu_mem(cpu_x, ALU_SBB);
      OP_AND:   alu_mem(cpu_x, ALU_AND);
      OP_OR:    alu_mem(cpu_x, ALU_OR);
      OP_RORX:  rotate_mem(cpu_x, 1'b0);
      OP_ROLX:  rotate_mem(cpu_x, 1'b1);
      OP_JMP:   cpu_pc = fetch24();
      OP_JZ:    begin t = fetch24(); if (cpu_zf) cpu_pc = t; end
      OP_JNZ:   begin t = fetch24(); if (!cpu_zf) cpu_pc = t; end
      OP_JC:    begin t = fetch24(); if (cpu_cf) cpu_pc = t; end
      OP_JNC:   begin t = fetch24(); if (!cpu_cf) cpu_pc = t; end
      OP_JMPX:  cpu_pc = cpu_x;
      OP_JMPY:  cpu_pc = cpu_y;
      OP_LYI:   cpu_y = fetch24();
      OP_LDY:   cpu_y = rd24(fetch24());
      OP_ADY:   begin t = fetch24(); cpu_y = add24(cpu_y, rd24(t)); end
      OP_SBY:   begin t = fetch24(); cpu_y = sub24(cpu_y, rd24(t)); end
      OP_STY:   wr24(fetch24(), cpu_y);
      OP_LD_Y:  cpu_acc = mem_rd(cpu_y);
      OP_ST_Y:  mem_wr(cpu_y, cpu_acc);
      OP_ADC_Y: alu_mem(cpu_y, ALU_ADC);
      OP_SBB_Y: alu_mem(cpu_y, ALU_SBB);
      OP_AND_Y: alu_mem(cpu_y, ALU_AND);
      OP_OR_Y:  alu_mem(cpu_y, ALU_OR);
      OP_CALL:  begin t = fetch24(); push24(cpu_pc); cpu_pc = t; end
      OP_RET:   cpu_pc = pop24();
      OP_PUSHA: push8(cpu_acc);
      OP_PUSHX: push24(cpu_x);
      OP_POPA:  cpu_acc = pop8();
      OP_POPX:  cpu_x = pop24();
      OP_TXS:   cpu_sp = cpu_x;
      OP_TSX:   cpu_x = cpu_sp;
      OP_INCX:  begin cpu_x = cpu_x + 24'd1; cpu_zf = (cpu_x == 24'd0); end
      OP_DECX:  begin cpu_x = cpu_x - 24'd1; cpu_zf = (cpu_x == 24'd0); end
      OP_INCY:  begin cpu_y = cpu_y + 24'd1; cpu_zf = (cpu_y == 24'd0); end
      OP_DECY:  begin cpu_y = cpu_y - 24'd1; cpu_zf = (cpu_y == 24'd0); end
      OP_RORY:  rotate_mem(cpu_y, 1'b0);
      OP_ROLY:  rotate_mem(cpu_y, 1'b1);
      default:  ; // undefined: only the opcode fetch moved the PC
    endcase
  endfunction

  // one transaction in, one step result out
  function automatic out_t cpu_step(in_t it);
    out_t r;
    r = '0;
    if (it.mode == MODE_LOAD) begin
      mem_wr(it.load_address, it.load_byte);
    end else if (!cpu_halt) begin
      run_instruction();
      if (it.key_code != 8'd0) mem_wr(PORT_KEY, it.key_code);
      // printer strobe: clear it and emit the data byte
      if (mem_rd(PORT_STROBE) != 8'd0) begin
        mem_wr(PORT_STROBE, 8'd0);
        r.char_valid = 1'b1;
        r.char_out   = mem_rd(PORT_DATA);
      end
    end
    r.halted    = cpu_halt;
    r.pc_out    = cpu_pc;
    r.acc_out   = cpu_acc;
    r.x_out     = cpu_x;
    r.y_out     = cpu_y;
    r.sp_out    = cpu_sp;
    r.carry_out = cpu_cf;
    r.zero_out  = cpu_zf;
    return r;
  endfunction

  function automatic int operand_bytes(logic [7:0] op);
    case (op)
      OP_LXI, OP_LDX, OP_ADX, OP_SBX, OP_STX, OP_JMP, OP_JZ, OP_JNZ, OP_JC,
      OP_JNC, OP_LYI, OP_LDY, OP_ADY, OP_SBY, OP_STY, OP_CALL: return 3;
      OP_LAI:  return 1;
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts with random gaps between them
  // ---------------------------------------------------------------------------
  int  burst_left;
  bit  gaps_off;
  int  accepted_cycles;

  function automatic int next_gap();
    if (gaps_off) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(1, 24);
    return $urandom_range(1, 7);
  endfunction

  // Called right after a posedge; valid stays high into the next item when
  // there is no gap; otherwise it is dropped for the gap and raised again.
  task automatic send_item(in_t it);
    int gap;
    gap = next_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    step_results_q.push_back(cpu_step(it));
  endtask

  function automatic in_t load_item(logic [23:0] a, logic [7:0] b);
    in_t it;
    it.mode         = MODE_LOAD;
    it.load_address = a;
    it.load_byte    = b;
    it.key_code     = $urandom_range(0, 255);
    return it;
  endfunction

  function automatic in_t exec_item(logic [7:0] key);
    in_t it;
    it.mode         = MODE_EXEC;
    it.load_address = $urandom_range(0, 24'hffffff);
    it.load_byte    = $urandom_range(0, 255);
    it.key_code     = key;
    return it;
  endfunction

  function automatic logic [7:0] rand_key();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
  endfunction

  // a zero byte at the PC would halt for good, so put an opcode there first
  task automatic exec_step(logic [7:0] key);
    logic [7:0] op;
    if (mem_rd(cpu_pc) == OP_HLT) begin
      op = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(47, 255))
                                       : 8'($urandom_range(1, 46));
      send_item(load_item(cpu_pc, op));
    end
    send_item(exec_item(key));
  endtask

  // drop valid, wait for every outstanding result, let the core settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (step_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_start_address(logic [23:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_START_ADDR;
    pwdata  <= {8'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cpu_start = value;
    cpu_pc    = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern that changes style, plus a long hold on request
  // ---------------------------------------------------------------------------
  bit hold_request;
  int hold_count;
  int style_left;
  int style;

  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_count   = LONG_HOLD;
    end
    if (style_left == 0) begin
      style_left = $urandom_range(30, 200);
      style      = $urandom_range(0, 3);
    end else begin
      style_left--;
    end
    if (hold_count > 0) begin
      hold_count--;
      out_ready <= 1'b0;
    end else begin
      case (style)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 0);
        2:       out_ready <= ($urandom_range(0, 4) == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: field by field against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (step_results_q.size() == 0) begin
        $error("result with no transaction outstanding: %h", out_data);
        error_count++;
      end else begin
        exp_r = step_results_q.pop_front();
        if (out_data.char_valid !== exp_r.char_valid) begin
          $error("char_valid exp %h got %h", exp_r.char_valid, out_data.char_valid);
          error_count++;
        end
        if (out_data.char_out !== exp_r.char_out) begin
          $error("char_out exp %h got %h", exp_r.char_out, out_data.char_out);
          error_count++;
        end
        if (out_data.halted !== exp_r.halted) begin
          $error("halted exp %h got %h", exp_r.halted, out_data.halted);
          error_count++;
        end
        if (out_data.pc_out !== exp_r.pc_out) begin
          $error("pc_out exp %h got %h", exp_r.pc_out, out_data.pc_out);
          error_count++;
        end
        if (out_data.acc_out !== exp_r.acc_out) begin
          $error("acc_out exp %h got %h", exp_r.acc_out, out_data.acc_out);
          error_count++;
        end
        if (out_data.x_out !== exp_r.x_out) begin
          $error("x_out exp %h got %h", exp_r.x_out, out_data.x_out);
          error_count++;
        end
        if (out_data.y_out !== exp_r.y_out) begin
          $error("y_out exp %h got %h", exp_r.y_out, out_data.y_out);
          error_count++;
        end
        if (out_data.sp_out !== exp_r.sp_out) begin
          $error("sp_out exp %h got %h", exp_r.sp_out, out_data.sp_out);
          error_count++;
        end
        if (out_data.carry_out !== exp_r.carry_out) begin
          $error("carry_out exp %h got %h", exp_r.carry_out, out_data.carry_out);
          error_count++;
        end
        if (out_data.zero_out !== exp_r.zero_out) begin
          $error("zero_out exp %h got %h", exp_r.zero_out, out_data.zero_out);
          error_count++;
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel or the APB port
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      accepted_cycles = 0;
    end else begin
      accepted_cycles++;
      if (accepted_cycles >= IDLE_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic load_block(logic [23:0] a, logic [7:0] bytes[$]);
    foreach (bytes[i]) send_item(load_item(a + 24'(i), bytes[i]));
  endtask

  // Port printing, ADX zero from the unmasked sum, SBX borrow, undefined
  // opcode, a full key code; runs from the reset start address.
  task automatic test_directed();
    logic [7:0] prog[$];
    logic [7:0] word_one[$];
    prog = '{OP_LAI, 8'h41,
             OP_LXI, 8'hff, 8'hff, 8'hff,
             OP_ST,
             OP_LXI, 8'hfe, 8'hff, 8'hff,
             OP_ST,                            // strobe set: character goes out
             OP_INCX,
             OP_ADX, 8'h40, 8'h00, 8'h07,      // 0xffffff + 1: carry, zero clear
             OP_SBX, 8'h40, 8'h00, 8'h07,      // 0 - 1: borrow
             8'hff};
    word_one = '{8'h01, 8'h00, 8'h00};
    gaps_off = 1'b1;
    load_block(START_DEFAULT, prog);
    load_block(START_DEFAULT + 24'h40, word_one);
    gaps_off = 1'b0;
    exec_step(8'h00);
    exec_step(8'hff);
    repeat (7) exec_step(8'h00);
    drain();
  endtask

  task automatic load_random_program(logic [23:0] base, logic [23:0] window,
                                     int n_instr);
    logic [7:0]  op;
    logic [23:0] w;
    int          n;
    logic [23:0] a;
    a = base;
    for (int i = 0; i < n_instr; i++) begin
      op = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(47, 255))
                                        : 8'($urandom_range(1, 46));
      send_item(load_item(a, op));
      a = a + 24'd1;
      n = operand_bytes(op);
      if (n == 1) begin
        send_item(load_item(a, $urandom_range(0, 255)));
        a = a + 24'd1;
      end else if (n == 3) begin
        case (op)
          OP_JMP, OP_JZ, OP_JNZ, OP_JC, OP_JNC, OP_CALL:
            w = base + 24'($urandom_range(0, 4 * n_instr));
          OP_LXI, OP_LYI:
            case ($urandom_range(0, 3))
              0:       w = PORT_KEY + 24'($urandom_range(0, 2));
              1:       w = $urandom_range(0, 24'hffffff);
              default: w = window + 24'($urandom_range(0, 24));
            endcase
          default: w = window + 24'($urandom_range(0, 24));
        endcase
        send_item(load_item(a, w[7:0]));
        send_item(load_item(a + 24'd1, w[15:8]));
        send_item(load_item(a + 24'd2, w[23:16]));
        a = a + 24'd3;
      end
    end
  endtask

  // Well-formed programs with random content, salted with stray loads
  // (the printer strobe among them) and run with random key codes.
  task automatic test_random_programs(int n_phases);
    logic [23:0] window;
    logic [23:0] start;
    for (int p = 0; p < n_phases; p++) begin
      case (p % 6)
        0:       start = 24'h000000;
        1:       start = 24'hffffff;
        default: start = $urandom_range(0, 24'hffffff);
      endcase
      write_start_address(start);
      gaps_off = ($urandom_range(0, 3) == 0);
      window   = $urandom_range(0, 24'hffffff);
      for (int i = 0; i < 12; i++)
        send_item(load_item(window + 24'(i), $urandom_range(0, 255)));
      load_random_program(start, window, 10);
      for (int i = 0; i < 40; i++) begin
        case ($urandom_range(0, 19))
          0:       send_item(load_item(PORT_STROBE, $urandom_range(0, 255)));
          1, 2:    send_item(load_item($urandom_range(0, 24'hffffff),
                                       $urandom_range(0, 255)));
          default: exec_step(rand_key());
        endcase
      end
      drain();
    end
  endtask

  // long stall on the result side while items keep coming
  task automatic test_backpressure();
    gaps_off     = 1'b1;
    hold_request = 1'b1;
    for (int i = 0; i < 30; i++) exec_step(rand_key());
    gaps_off = 1'b0;
    drain();
  endtask

  // HLT is sticky: later steps change nothing and print nothing, loads still land
  task automatic test_halt();
    logic [7:0] halt_op[$];
    halt_op = '{OP_HLT};
    send_item(load_item(PORT_STROBE, 8'h5a));
    load_block(cpu_pc, halt_op);
    send_item(exec_item(8'h00));
    send_item(load_item(PORT_STROBE, 8'h33));
    repeat (3) send_item(exec_item(8'hff));
    send_item(load_item(24'h000010, 8'haa));
    send_item(exec_item(8'h00));
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    out_ready    = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    error_count  = 0;
    burst_left   = 0;
    gaps_off     = 1'b0;
    hold_request = 1'b0;
    hold_count   = 0;
    style_left   = 0;
    style        = 0;
    accepted_cycles = 0;
    cpu_start = START_DEFAULT;
    cpu_pc    = START_DEFAULT;
    cpu_sp    = '0;
    cpu_x     = '0;
    cpu_y     = '0;
    cpu_acc   = '0;
    cpu_cf    = 1'b0;
    cpu_zf    = 1'b0;
    cpu_halt  = 1'b0;
    for (int i = 0; i < MEM_SIZE; i++) cpu_mem[i] = 8'd0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_programs(20);
    test_backpressure();
    test_random_programs(4);
    test_halt();

    repeat (SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/acs_pkg.sv
rtl/acs_alu.sv
rtl/acs_mem.sv
rtl/acs_core.sv
rtl/accumulator_cpu_step.sv
verif/testbench.sv
